/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define CCTL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Condition that must never hold outside reset.
`define CCTL_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* rtl/cctl_pkg.sv */
// ----------------------------------------------------------------------------
// cctl_pkg
// Shared constants and types for the cache tag lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package cctl_pkg;

  localparam int MAX_BLOCKS_DEF = 64;

  localparam int ADDR_W     = 32;
  localparam int TAG_W      = 32;
  localparam int AGE_W      = 16;
  localparam int BLK_OUT_W  = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PLACEMENT  = 3'd0,
    CFG_REPLACE    = 3'd1,
    CFG_BLOCKS     = 3'd2,
    CFG_WAYS       = 3'd3,
    CFG_LINE_WORDS = 3'd4
  } cfg_reg_t;

  localparam logic [1:0] PL_DIRECT = 2'd0;
  localparam logic [1:0] PL_FULL   = 2'd1;
  localparam logic [1:0] PL_SET    = 2'd2;

  localparam logic RP_MRU = 1'b0;
  localparam logic RP_LRU = 1'b1;

  localparam logic [1:0] PLACEMENT_RST  = PL_SET;
  localparam logic       REPLACE_RST    = RP_LRU;
  localparam logic [2:0] BLOCKS_RST     = 3'd4;
  localparam logic [2:0] WAYS_RST       = 3'd1;
  localparam logic [3:0] LINE_WORDS_RST = 4'd4;

endpackage

`default_nettype wire

/* rtl/configurable_cache_tag_lookup_top.sv */
// ----------------------------------------------------------------------------
// configurable_cache_tag_lookup_top
// Cache tag lookup with direct, fully or set associative placement and
// LRU or MRU replacement, driven by one sequencer over shared RAM ports.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one byte address per transfer (in_valid / in_stall).
//   out_* : hit, block index and evicted flag per transfer
//           (out_valid / out_stall), one result per address.
//   cfg_* : register writes (cfg_valid / cfg_ready, ready always high);
//           write only while the block is idle.
//   Timing: after an address transfer the set's ways are read one per
//   cycle through the tag and age RAM read ports (1 way direct mapped,
//   2**blocks_log2 fully associative); the last way is compared in
//   ST_WAIT and the result is committed in ST_DONE. No new address is
//   taken until the result of the last one has been committed.
//   Reset: the RAMs are swept one entry per cycle over all MAX_BLOCKS
//   entries; in_stall stays high meanwhile.
//   Stall: a result waits in the output register; the next address is
//   accepted and searched, and its commit waits until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module configurable_cache_tag_lookup_top #(
  parameter int MAX_BLOCKS = cctl_pkg::MAX_BLOCKS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [cctl_pkg::ADDR_W-1:0]      in_address,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_hit,
  output logic [cctl_pkg::BLK_OUT_W-1:0]        out_block_index,
  output logic                                  out_evicted,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [cctl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [cctl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import cctl_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int BMAX  = $clog2(MAX_BLOCKS + 1) - 1;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_WAIT   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [1:0] placement_r;
  logic       replace_r;
  logic [2:0] blocks_log2_r;
  logic [2:0] ways_log2_r;
  logic [3:0] line_words_log2_r;

  // per-item context
  logic [TAG_W-1:0] tag_r;
  logic [IDX_W-1:0] start_r, way_mask_r, set_r;
  logic             direct_r;
  logic [IDX_W-1:0] k_r;
  logic [IDX_W-1:0] clr_r;

  // compare stage
  logic             cmp_vld_r, cmp_first_r;
  logic [IDX_W-1:0] cmp_idx_r;

  // search results
  logic             found_r, inv_found_r;
  logic [IDX_W-1:0] found_idx_r, inv_idx_r, best_idx_r;
  logic [AGE_W-1:0] best_age_r;

  // output register
  logic                 out_valid_r, out_hit_r, out_evicted_r;
  logic [BLK_OUT_W-1:0] out_block_index_r;

  // geometry of the incoming address
  logic [2:0]        b_eff, w_eff, sb;
  logic [4:0]        off;
  logic [ADDR_W-1:0] line, set32;
  logic [TAG_W-1:0]  tag_nxt;

  // RAM ports
  logic             tag_we, age_we, rec_we;
  logic [IDX_W-1:0] tag_waddr, age_waddr, rec_waddr, rd_addr;
  logic [TAG_W:0]   tag_wdata, tag_rdata;
  logic [AGE_W-1:0] age_wdata, age_rdata, age_inc;
  logic [IDX_W-1:0] rec_wdata, rec_rdata;

  logic             accept, commit, lru_touch;
  logic [IDX_W-1:0] victim_idx, sel_idx;
  logic             sel_evicted;

  assign accept    = in_valid && !in_stall;
  assign commit    = (state_r == ST_DONE) && (!out_valid_r || !out_stall);
  assign lru_touch = !direct_r && (replace_r == RP_LRU);

  always_comb begin
    b_eff = (32'(blocks_log2_r) > BMAX) ? 3'(BMAX) : blocks_log2_r;
    if (placement_r == PL_DIRECT) begin
      w_eff = 3'd0;
    end else if (placement_r == PL_FULL) begin
      w_eff = b_eff;
    end else begin
      w_eff = (ways_log2_r > b_eff) ? b_eff : ways_log2_r;
    end
    sb      = b_eff - w_eff;
    off     = 5'(line_words_log2_r) + 5'd2;
    line    = in_address >> off;
    set32   = line & ~(32'hFFFF_FFFF << sb);
    tag_nxt = line >> sb;
  end

  // victim choice and result selection
  always_comb begin
    if (direct_r) begin
      victim_idx = start_r;
    end else if (replace_r == RP_LRU) begin
      victim_idx = best_idx_r;
    end else begin
      victim_idx = start_r | (rec_rdata & way_mask_r);
    end
    sel_evicted = 1'b0;
    if (found_r) begin
      sel_idx = found_idx_r;
    end else if (inv_found_r) begin
      sel_idx = inv_idx_r;
    end else begin
      sel_idx     = victim_idx;
      sel_evicted = 1'b1;
    end
  end

  assign rd_addr = start_r | k_r;
  assign age_inc = (age_rdata == '1) ? age_rdata : age_rdata + AGE_W'(1);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_r == IDX_W'(MAX_BLOCKS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (k_r == way_mask_r) begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: state_nxt = ST_DONE;
      ST_DONE: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // RAM write muxes
  always_comb begin
    tag_we    = 1'b0;
    tag_waddr = sel_idx;
    tag_wdata = {1'b1, tag_r};
    age_we    = 1'b0;
    age_waddr = sel_idx;
    age_wdata = '0;
    rec_we    = 1'b0;
    rec_waddr = set_r;
    rec_wdata = sel_idx & way_mask_r;
    if (state_r == ST_CLEAR) begin
      tag_we    = 1'b1;
      tag_waddr = clr_r;
      tag_wdata = '0;
      age_we    = 1'b1;
      age_waddr = clr_r;
      rec_we    = 1'b1;
      rec_waddr = clr_r;
      rec_wdata = '0;
    end else if (commit) begin
      tag_we = !found_r;
      age_we = lru_touch;
      rec_we = !direct_r && (replace_r == RP_MRU);
    end else if (cmp_vld_r && lru_touch) begin
      age_we    = 1'b1;
      age_waddr = cmp_idx_r;
      age_wdata = age_inc;
    end
  end

  cctl_ram #(.WIDTH(TAG_W + 1), .DEPTH(MAX_BLOCKS)) u_tag_ram (
    .clk     (clk),
    .wr_en   (tag_we),
    .wr_addr (tag_waddr),
    .wr_data (tag_wdata),
    .rd_addr (rd_addr),
    .rd_data (tag_rdata)
  );

  cctl_ram #(.WIDTH(AGE_W), .DEPTH(MAX_BLOCKS)) u_age_ram (
    .clk     (clk),
    .wr_en   (age_we),
    .wr_addr (age_waddr),
    .wr_data (age_wdata),
    .rd_addr (rd_addr),
    .rd_data (age_rdata)
  );

  cctl_ram #(.WIDTH(IDX_W), .DEPTH(MAX_BLOCKS)) u_recent_ram (
    .clk     (clk),
    .wr_en   (rec_we),
    .wr_addr (rec_waddr),
    .wr_data (rec_wdata),
    .rd_addr (set_r),
    .rd_data (rec_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      placement_r       <= PLACEMENT_RST;
      replace_r         <= REPLACE_RST;
      blocks_log2_r     <= BLOCKS_RST;
      ways_log2_r       <= WAYS_RST;
      line_words_log2_r <= LINE_WORDS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PLACEMENT:  placement_r       <= cfg_data[1:0];
        CFG_REPLACE:    replace_r         <= cfg_data[0];
        CFG_BLOCKS:     blocks_log2_r     <= cfg_data[2:0];
        CFG_WAYS:       ways_log2_r       <= cfg_data[2:0];
        CFG_LINE_WORDS: line_words_log2_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // sequencer and search
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      k_r         <= '0;
      cmp_vld_r   <= 1'b0;
      cmp_first_r <= 1'b0;
      found_r     <= 1'b0;
      inv_found_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cmp_vld_r   <= (state_r == ST_SEARCH);
      cmp_first_r <= (state_r == ST_SEARCH) && (k_r == '0);
      cmp_idx_r   <= rd_addr;

      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + IDX_W'(1);
      end

      if (accept) begin
        tag_r       <= tag_nxt;
        set_r       <= IDX_W'(set32);
        start_r     <= IDX_W'(set32 << w_eff);
        way_mask_r  <= IDX_W'(~(32'hFFFF_FFFF << w_eff));
        direct_r    <= (placement_r == PL_DIRECT);
        k_r         <= '0;
        found_r     <= 1'b0;
        inv_found_r <= 1'b0;
      end else if (state_r == ST_SEARCH) begin
        k_r <= k_r + IDX_W'(1);
      end

      if (cmp_vld_r) begin
        if (tag_rdata[TAG_W] && (tag_rdata[TAG_W-1:0] == tag_r)) begin
          found_r     <= 1'b1;
          found_idx_r <= cmp_idx_r;
        end
        if (!tag_rdata[TAG_W] && !inv_found_r) begin
          inv_found_r <= 1'b1;
          inv_idx_r   <= cmp_idx_r;
        end
        if (cmp_first_r || (age_rdata > best_age_r)) begin
          best_age_r <= age_rdata;
          best_idx_r <= cmp_idx_r;
        end
      end

      if (commit) begin
        out_valid_r       <= 1'b1;
        out_hit_r         <= found_r;
        out_evicted_r     <= sel_evicted;
        out_block_index_r <= BLK_OUT_W'(sel_idx);
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_stall        = (state_r != ST_IDLE);
  assign cfg_ready       = 1'b1;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_evicted     = out_evicted_r;
  assign out_block_index = out_block_index_r;

`include "assert_macros.svh"

  `CCTL_NEVER(a_hit_and_evict, clk, rst_n, out_valid_r && out_hit_r && out_evicted_r)
  `CCTL_ASSERT(a_way_in_set, clk, rst_n, (state_r == ST_SEARCH) |-> ((k_r & ~way_mask_r) == '0))
  `CCTL_ASSERT(a_accept_search, clk, rst_n, accept |=> (state_r == ST_SEARCH))
  `CCTL_ASSERT(a_result_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_DONE))

endmodule

`default_nettype wire

/* rtl/cctl_ram.sv */
// ----------------------------------------------------------------------------
// cctl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cctl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire
